FILE: rtl/base64_stream_encoder_macros.svh
// Assertion macros shared by the encoder RTL.
`ifndef BASE64_STREAM_ENCODER_MACROS_SVH
`define BASE64_STREAM_ENCODER_MACROS_SVH

`ifndef SYNTHESIS

`define B64E_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

`define B64E_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define B64E_ASSERT_SAME(lbl, clk, rstn, ante, cons)

`define B64E_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

FILE: rtl/b64e_pkg.sv
package b64e_pkg;

    localparam logic [7:0] C_PAD_CHAR = 8'h3D;
    localparam logic [5:0] C_SLICE_MASK = 6'h3F;

    typedef enum logic [1:0] {
        PH_EMPTY,
        PH_ONE,
        PH_TWO
    } t_phase;

    typedef struct packed {
        logic [23:0] word;
        logic [1:0]  nbytes;
        logic        fin;
    } t_group;

    typedef struct packed {
        logic   valid;
        t_group grp;
    } t_push;

    function automatic logic [7:0] char_of(input logic [5:0] idx);
        logic [7:0] v;
        v = {2'b00, idx & C_SLICE_MASK};
        if (v < 8'd26) begin
            char_of = 8'h41 + v;
        end else if (v < 8'd52) begin
            char_of = 8'h61 + (v - 8'd26);
        end else if (v < 8'd62) begin
            char_of = 8'h30 + (v - 8'd52);
        end else if (v == 8'd62) begin
            char_of = 8'h2B;
        end else begin
            char_of = 8'h2F;
        end
    endfunction

endpackage

FILE: rtl/b64e_front.sv
`include "base64_stream_encoder_macros.svh"

module b64e_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_q_ready,
    input  logic [7:0]       i_data_byte,
    input  logic             i_final_byte,
    output b64e_pkg::t_push  o_push
);

    b64e_pkg::t_phase r_phase, n_phase;
    logic [15:0]      r_pend, n_pend;
    logic             w_accept;

    assign w_accept = i_in_valid && i_q_ready;

    always_comb begin
        n_phase = r_phase;
        n_pend  = r_pend;
        if (w_accept) begin
            case (r_phase)
                b64e_pkg::PH_ONE: begin
                    if (i_final_byte) begin
                        n_phase = b64e_pkg::PH_EMPTY;
                        n_pend  = 16'h0000;
                    end else begin
                        n_phase = b64e_pkg::PH_TWO;
                        n_pend  = {r_pend[7:0], i_data_byte};
                    end
                end
                b64e_pkg::PH_TWO: begin
                    n_phase = b64e_pkg::PH_EMPTY;
                    n_pend  = 16'h0000;
                end
                default: begin
                    if (i_final_byte) begin
                        n_phase = b64e_pkg::PH_EMPTY;
                        n_pend  = 16'h0000;
                    end else begin
                        n_phase = b64e_pkg::PH_ONE;
                        n_pend  = {8'h00, i_data_byte};
                    end
                end
            endcase
        end
    end

    always_comb begin
        o_push = '0;
        case (r_phase)
            b64e_pkg::PH_ONE: begin
                o_push.valid      = w_accept && i_final_byte;
                o_push.grp.word   = {r_pend[7:0], i_data_byte, 8'h00};
                o_push.grp.nbytes = 2'd2;
                o_push.grp.fin    = 1'b1;
            end
            b64e_pkg::PH_TWO: begin
                o_push.valid      = w_accept;
                o_push.grp.word   = {r_pend, i_data_byte};
                o_push.grp.nbytes = 2'd3;
                o_push.grp.fin    = i_final_byte;
            end
            default: begin
                o_push.valid      = w_accept && i_final_byte;
                o_push.grp.word   = {i_data_byte, 16'h0000};
                o_push.grp.nbytes = 2'd1;
                o_push.grp.fin    = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= b64e_pkg::PH_EMPTY;
            r_pend  <= 16'h0000;
        end else begin
            r_phase <= n_phase;
            r_pend  <= n_pend;
        end
    end

    `B64E_ASSERT_NEXT(a_push_empties, i_clk, i_rst_n, o_push.valid, r_phase == b64e_pkg::PH_EMPTY)

endmodule

FILE: rtl/b64e_fifo.sv
`include "base64_stream_encoder_macros.svh"

module b64e_fifo #(
    parameter int P_DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  b64e_pkg::t_push   i_push,
    output logic              o_ready,
    input  logic              i_pop,
    output logic              o_valid,
    output b64e_pkg::t_group  o_grp
);

    localparam int AW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CW = $clog2(P_DEPTH + 1);

    b64e_pkg::t_group r_mem [P_DEPTH];
    logic [AW-1:0]    r_wr, n_wr, r_rd, n_rd;
    logic [CW-1:0]    r_count, n_count;
    logic             w_push, w_pop;

    assign o_ready = (r_count != CW'(P_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_grp   = r_mem[r_rd];
    assign w_push  = i_push.valid && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (w_push) begin
            n_wr = (r_wr == AW'(P_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_pop) begin
            n_rd = (r_rd == AW'(P_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_push.grp;
        end
    end

    `B64E_ASSERT_SAME(a_no_overflow, i_clk, i_rst_n, !o_ready, !i_push.valid)

endmodule

FILE: rtl/b64e_back.sv
`include "base64_stream_encoder_macros.svh"

module b64e_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  b64e_pkg::t_group  i_q_grp,
    output logic              o_q_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [7:0]        o_out_char,
    output logic              o_run_end,
    output logic              o_stream_end
);

    b64e_pkg::t_group r_grp;
    logic             r_grp_valid, n_grp_valid;
    logic [1:0]       r_idx, n_idx;
    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_char, n_char;
    logic             r_run_end, n_run_end;
    logic             r_stream_end, n_stream_end;
    logic             w_load, w_last, w_free;
    logic [7:0]       w_char;

    assign w_load  = r_grp_valid && (!r_out_valid || i_out_ready);
    assign w_last  = (r_idx == 2'd3);
    assign w_free  = !r_grp_valid || (w_load && w_last);
    assign o_q_pop = i_q_valid && w_free;

    always_comb begin
        case (r_idx)
            2'd0: w_char = b64e_pkg::char_of(r_grp.word[23:18]);
            2'd1: w_char = b64e_pkg::char_of(r_grp.word[17:12]);
            2'd2: w_char = (r_grp.nbytes >= 2'd2) ? b64e_pkg::char_of(r_grp.word[11:6])
                                                  : b64e_pkg::C_PAD_CHAR;
            default: w_char = (r_grp.nbytes == 2'd3) ? b64e_pkg::char_of(r_grp.word[5:0])
                                                     : b64e_pkg::C_PAD_CHAR;
        endcase
    end

    always_comb begin
        n_grp_valid = r_grp_valid;
        n_idx       = r_idx;
        if (w_load) begin
            n_idx = r_idx + 2'd1;
        end
        if (w_free) begin
            n_grp_valid = i_q_valid;
            n_idx       = 2'd0;
        end
    end

    always_comb begin
        n_out_valid  = r_out_valid;
        n_char       = r_char;
        n_run_end    = r_run_end;
        n_stream_end = r_stream_end;
        if (w_load) begin
            n_out_valid  = 1'b1;
            n_char       = w_char;
            n_run_end    = w_last;
            n_stream_end = w_last && r_grp.fin;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp_valid <= 1'b0;
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_grp_valid <= n_grp_valid;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_grp <= i_q_grp;
        end
        r_char       <= n_char;
        r_run_end    <= n_run_end;
        r_stream_end <= n_stream_end;
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_char   = r_char;
    assign o_run_end    = r_run_end;
    assign o_stream_end = r_stream_end;

    `B64E_ASSERT_SAME(a_idle_idx_zero, i_clk, i_rst_n, !r_grp_valid, r_idx == 2'd0)
    `B64E_ASSERT_SAME(a_end_in_run, i_clk, i_rst_n, r_out_valid && r_stream_end, r_run_end)

endmodule

FILE: rtl/base64_stream_encoder.sv
// Base64 (standard alphabet) stream encoder.
// Input channel: i_in_valid / o_in_ready with i_data_byte and i_final_byte,
// one byte per transaction; i_final_byte marks the last byte of a stream.
// Output channel: o_out_valid / i_out_ready with o_out_char (ASCII),
// o_run_end on the last character of each four-character group, and
// o_stream_end on the last character of the encoded stream.
// Every third byte, or a final byte, produces four characters; short final
// groups are zero padded and closed with '=' characters.
// A group closed by a byte is written into the queue, then loaded into the
// back end's group register; its characters leave through the output register.
// Throughput: the output side sends one character per cycle while the
// receiver is ready; the input takes a byte every cycle
// while the group queue (P_QUEUE_DEPTH entries) has room.
// Reset clears the pending bytes, empties the queue and drops o_out_valid.
// When the receiver stalls, the output register holds, the queue fills and
// then o_in_ready stays low until the back end starts its next group,
// which frees a queue entry.
module base64_stream_encoder #(
    parameter int P_QUEUE_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_final_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_char,
    output logic       o_run_end,
    output logic       o_stream_end
);

    b64e_pkg::t_push  w_push;
    b64e_pkg::t_group w_q_grp;
    logic             w_q_ready, w_q_valid, w_q_pop;

    assign o_in_ready = w_q_ready;

    b64e_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_q_ready    (w_q_ready),
        .i_data_byte  (i_data_byte),
        .i_final_byte (i_final_byte),
        .o_push       (w_push)
    );

    b64e_fifo #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_ready (w_q_ready),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_grp   (w_q_grp)
    );

    b64e_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (w_q_valid),
        .i_q_grp      (w_q_grp),
        .o_q_pop      (w_q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_char   (o_out_char),
        .o_run_end    (o_run_end),
        .o_stream_end (o_stream_end)
    );

endmodule

FILE: tb/base64_stream_encoder_tb.sv
`timescale 1ns / 1ps

module base64_stream_encoder_tb;

    localparam int C_NUM_BYTES   = 420;
    localparam int C_CYCLE_LIMIT = 200000;
    localparam int C_DRAIN_WAIT  = 16;
    localparam int C_LONG_HOLD   = 250;

    typedef struct {
        logic [7:0] ch;
        logic       run_end;
        logic       stream_end;
    } t_b64_char;

    class b64_scoreboard;
        b64e_pkg::t_phase phase;
        logic [15:0]      held;
        t_b64_char        expected_chars[$];
        int               errors;

        function new();
            phase  = b64e_pkg::PH_EMPTY;
            held   = '0;
            errors = 0;
        endfunction

        function logic [7:0] b64_digit(input logic [5:0] idx);
            string alpha = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
            return alpha[int'(idx)];
        endfunction

        // nreal data bytes in word[23:0]; missing tail characters become pads
        function void push_group(input logic [23:0] word, input int nreal, input logic fin);
            t_b64_char c;
            for (int k = 0; k < 4; k++) begin
                if (k >= nreal + 1) begin
                    c.ch = b64e_pkg::C_PAD_CHAR;
                end else begin
                    c.ch = b64_digit(word[23 - 6 * k -: 6]);
                end
                c.run_end    = (k == 3);
                c.stream_end = (k == 3) && fin;
                expected_chars.push_back(c);
            end
        endfunction

        function void note_byte(input logic [7:0] b, input logic fin);
            case (phase)
                b64e_pkg::PH_ONE: begin
                    if (fin) begin
                        push_group({held[7:0], b, 8'h00}, 2, 1'b1);
                        phase = b64e_pkg::PH_EMPTY;
                        held  = '0;
                    end else begin
                        held  = {held[7:0], b};
                        phase = b64e_pkg::PH_TWO;
                    end
                end
                b64e_pkg::PH_TWO: begin
                    push_group({held, b}, 3, fin);
                    phase = b64e_pkg::PH_EMPTY;
                    held  = '0;
                end
                default: begin
                    if (fin) begin
                        push_group({b, 16'h0000}, 1, 1'b1);
                        phase = b64e_pkg::PH_EMPTY;
                        held  = '0;
                    end else begin
                        held  = {8'h00, b};
                        phase = b64e_pkg::PH_ONE;
                    end
                end
            endcase
        endfunction

        function void check_char(input logic [7:0] ch, input logic re, input logic se);
            t_b64_char e;
            if (expected_chars.size() == 0) begin
                $display("%0t: unexpected character 0x%02h run_end=%0b stream_end=%0b",
                         $time, ch, re, se);
                errors++;
                return;
            end
            e = expected_chars.pop_front();
            if (ch !== e.ch) begin
                $display("%0t: out_char expected 0x%02h actual 0x%02h", $time, e.ch, ch);
                errors++;
            end
            if (re !== e.run_end) begin
                $display("%0t: run_end expected %0b actual %0b", $time, e.run_end, re);
                errors++;
            end
            if (se !== e.stream_end) begin
                $display("%0t: stream_end expected %0b actual %0b", $time, e.stream_end, se);
                errors++;
            end
        endfunction

        function int outstanding();
            return expected_chars.size();
        endfunction
    endclass

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_in_valid   = 1'b0;
    logic       o_in_ready;
    logic [7:0] i_data_byte  = 8'h00;
    logic       i_final_byte = 1'b0;
    logic       o_out_valid;
    logic       i_out_ready  = 1'b0;
    logic [7:0] o_out_char;
    logic       o_run_end;
    logic       o_stream_end;

    b64_scoreboard sb = new();

    int cycle_count  = 0;
    int bytes_sent   = 0;
    int tx_mode      = 1;
    int rx_mode      = 1;
    int rx_gap_left  = 0;
    int rx_hold_left = 0;
    int rx_hold_req  = 0;

    base64_stream_encoder dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_data_byte  (i_data_byte),
        .i_final_byte (i_final_byte),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_char   (o_out_char),
        .o_run_end    (o_run_end),
        .o_stream_end (o_stream_end)
    );

    initial begin
        forever begin
            #4 i_clk = ~i_clk;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > C_CYCLE_LIMIT) begin
            $display("base64_stream_encoder regression: fail");
            $finish;
        end
    end

    // mode 0: no idling, 1: uniform gaps, 2: rare gaps
    function automatic int draw_gap(input int mode);
        case (mode)
            0:       return 0;
            1:       return $urandom_range(0, 13);
            default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
        endcase
    endfunction

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = draw_gap(tx_mode);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_data_byte  <= b;
        i_final_byte <= fin;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        sb.note_byte(b, fin);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_random_stream(input int len);
        logic fin;
        for (int i = 0; i < len; i++) begin
            // occasional early final breaks a stream short
            fin = (i == len - 1) || ($urandom_range(0, 19) == 0);
            send_byte(rand_byte(), fin);
        end
    endtask

    // receiver side
    initial begin
        forever begin
            @(negedge i_clk);
            if (rx_hold_req > 0) begin
                rx_hold_left = rx_hold_req;
                rx_hold_req  = 0;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                i_out_ready <= 1'b0;
            end else if (rx_gap_left > 0) begin
                rx_gap_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_char(o_out_char, o_run_end, o_stream_end);
            if ($urandom_range(0, 29) == 0) begin
                rx_mode = $urandom_range(0, 2);
            end
            rx_gap_left = draw_gap(rx_mode);
        end
    end

    initial begin
        int  len;
        bit  hold_done;
        hold_done = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // one-byte streams: "AA==", "/w=="
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        // two-byte streams: "//8=", "AIA="
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b1);
        // full group not final, then final completing a group
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        // new stream after final; '+' digits
        send_byte(8'hFB, 1'b0);
        send_byte(8'hEF, 1'b0);
        send_byte(8'hBE, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h10, 1'b0);
        send_byte(8'h83, 1'b1);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h5A, 1'b1);

        while (bytes_sent < C_NUM_BYTES) begin
            if ($urandom_range(0, 3) == 0) begin
                tx_mode = $urandom_range(0, 2);
            end
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            if (!hold_done && bytes_sent > 150) begin
                // receiver stalls long while the sender keeps pushing
                hold_done   = 1'b1;
                tx_mode     = 0;
                rx_hold_req = C_LONG_HOLD;
                len         = 30;
            end
            send_random_stream(len);
        end
        i_in_valid <= 1'b0;

        while (sb.outstanding() > 0) begin
            @(posedge i_clk);
        end
        repeat (C_DRAIN_WAIT) @(posedge i_clk);

        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("base64_stream_encoder regression: pass");
        end else begin
            if (sb.outstanding() > 0) begin
                $display("%0t: %0d expected characters never arrived", $time, sb.outstanding());
            end
            $display("base64_stream_encoder regression: fail");
        end
        $finish;
    end

endmodule
